>>> design/radix2_fft_assert.svh
// Assertion macros for the radix-2 FFT block.
// Used by the top-level module; no other dependencies.
`ifndef RADIX2_FFT_ASSERT_SVH
`define RADIX2_FFT_ASSERT_SVH
`ifndef SYNTH
`define FFT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FFT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define FFT_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> design/fft_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions for the radix-2 FFT block.
// No dependencies.
package fft_pkg;
    localparam int POINTS = 64;
    localparam int LOG2_POINTS = 6;
    localparam int DW = 23;
    localparam int IW = 16;
    localparam int AW = LOG2_POINTS;
    localparam int ENTRY_W = 2 * DW;

    typedef logic [AW-1:0] addr_t;
    typedef logic signed [DW-1:0] data_t;

    typedef struct packed {
        logic          wr_en;
        addr_t         wr_addr;
        logic          rd_en;
        addr_t         rd_addr;
        logic [4:0]    tw_k;
        logic          inv;
    } bfly_ctl_t;

    function automatic logic signed [15:0] quarter_cos(input logic [4:0] k);
        logic signed [15:0] v;
        case (k)
            5'd0: v = 16'sd32767;   5'd1: v = 16'sd32610;   5'd2: v = 16'sd32138;
            5'd3: v = 16'sd31357;   5'd4: v = 16'sd30274;   5'd5: v = 16'sd28899;
            5'd6: v = 16'sd27246;   5'd7: v = 16'sd25330;   5'd8: v = 16'sd23170;
            5'd9: v = 16'sd20788;   5'd10: v = 16'sd18205;  5'd11: v = 16'sd15447;
            5'd12: v = 16'sd12540;  5'd13: v = 16'sd9512;   5'd14: v = 16'sd6393;
            5'd15: v = 16'sd3212;   default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic addr_t bit_rev(input addr_t i);
        addr_t r;
        for (int b = 0; b < AW; b++)
            r[AW-1-b] = i[b];
        return r;
    endfunction

    function automatic data_t sat23(input logic signed [DW+1:0] v);
        data_t r;
        if (v > $signed({{2{1'b0}}, 1'b0, {(DW-1){1'b1}}}))
            r = {1'b0, {(DW-1){1'b1}}};
        else if (v < $signed({{2{1'b1}}, 1'b1, {(DW-1){1'b0}}}))
            r = {1'b1, {(DW-1){1'b0}}};
        else
            r = v[DW-1:0];
        return r;
    endfunction
endpackage

>>> design/radix2_fft.sv
`timescale 1ns / 1ps
// Radix-2 DIT FFT top level: sequencer, frame memory and butterfly unit.
// Depends on fft_pkg, fft_ram, fft_bfly and radix2_fft_assert.svh.
//
// Usage:
//   Pulse start with sample_re/sample_im while busy is low; each accepted
//   word is written bit-reversed into the frame memory.
//   The 64th word starts the transform: 6 stages x 32 butterflies, each
//   butterfly stepping in order on the single memory port pair (read a,
//   read b, multiply, write a, write b); then 64 results leave one per
//   cycle, read through the registered memory port, with valid high for
//   one cycle each; bin_index counts 0..63 and frame_last marks index 63.
//   Busy is high from the last sample until the final result has gone.
//   A new frame cannot be loaded until then, since the one butterfly unit
//   shares the frame memory ports.
//   inverse_mode is written through cfg_valid/cfg_ready (ready always
//   high) and sampled when the last sample is taken.
//   Reset clears the load count, the mode and the sequencer; memory
//   contents are left as they are. The receiver cannot stall results.
module radix2_fft (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [15:0]      sample_re,
    input  logic signed [15:0]      sample_im,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data,
    output logic                    valid,
    output logic signed [22:0]      bin_re,
    output logic signed [22:0]      bin_im,
    output logic [5:0]              bin_index,
    output logic                    frame_last
);
    import fft_pkg::*;
    `include "radix2_fft_assert.svh"

    typedef enum logic [2:0] {
        S_LOAD, S_RDA, S_RDB, S_MUL, S_WRA, S_WRB, S_OUT, S_OUTLAST
    } state_t;

    state_t state_reg;
    logic inverse_mode_reg, inv_reg;
    logic [AW:0] load_count_reg;
    logic [2:0] stage_reg;
    logic [AW-2:0] bf_reg;
    logic [AW:0] out_cnt_reg;
    data_t a_re_reg, a_im_reg;

    bfly_ctl_t ctl;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    data_t sum_re, sum_im, dif_re, dif_im;
    addr_t ia, ib;
    logic [AW-1:0] half, kk;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != S_LOAD);

    always_comb
    begin
        half = addr_t'(1) << stage_reg;
        kk = addr_t'(bf_reg) & (half - addr_t'(1));
        ia = addr_t'(((addr_t'(bf_reg) & ~(half - addr_t'(1))) << 1) | kk);
        ib = ia | half;
    end

    always_comb
    begin
        ctl.wr_en = 1'b0;
        ctl.wr_addr = ia;
        ctl.rd_en = 1'b0;
        ctl.rd_addr = ia;
        ctl.tw_k = 5'(kk << (3'd5 - stage_reg));
        ctl.inv = inv_reg;
        wr_data = {sum_re, sum_im};
        unique case (state_reg)
            S_LOAD:
            begin
                ctl.wr_en = start;
                ctl.wr_addr = bit_rev(load_count_reg[AW-1:0]);
                wr_data = {DW'(sample_re), DW'(sample_im)};
            end
            S_RDA: ctl.rd_en = 1'b1;
            S_RDB:
            begin
                ctl.rd_en = 1'b1;
                ctl.rd_addr = ib;
            end
            S_MUL: ;
            S_WRA: ctl.wr_en = 1'b1;
            S_WRB:
            begin
                ctl.wr_en = 1'b1;
                ctl.wr_addr = ib;
                wr_data = {dif_re, dif_im};
            end
            S_OUT, S_OUTLAST:
            begin
                ctl.rd_en = 1'b1;
                ctl.rd_addr = out_cnt_reg[AW-1:0];
            end
            default: ;
        endcase
    end

    fft_ram #(.WIDTH(ENTRY_W), .DEPTH(POINTS)) u_mem (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (ctl.wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.rd_addr),
        .rd_data (rd_data)
    );

    fft_bfly u_bfly (
        .clk     (clk),
        .tw_k    (ctl.tw_k),
        .inv     (ctl.inv),
        .a_re    (a_re_reg),
        .a_im    (a_im_reg),
        .b_re    (rd_data[ENTRY_W-1:DW]),
        .b_im    (rd_data[DW-1:0]),
        .prod_en (state_reg == S_MUL),
        .sum_re  (sum_re),
        .sum_im  (sum_im),
        .dif_re  (dif_re),
        .dif_im  (dif_im)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            inverse_mode_reg <= 1'b0;
            inv_reg <= 1'b0;
            load_count_reg <= '0;
            stage_reg <= '0;
            bf_reg <= '0;
            out_cnt_reg <= '0;
            a_re_reg <= '0;
            a_im_reg <= '0;
            valid <= 1'b0;
            frame_last <= 1'b0;
            bin_index <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                inverse_mode_reg <= cfg_data;
            valid <= (state_reg == S_OUT);
            frame_last <= (state_reg == S_OUT) && (out_cnt_reg == (AW+1)'(POINTS - 1));
            if (state_reg == S_OUT)
                bin_index <= out_cnt_reg[AW-1:0];
            unique case (state_reg)
                S_LOAD:
                    if (start)
                    begin
                        if (load_count_reg == (AW+1)'(POINTS - 1))
                        begin
                            load_count_reg <= '0;
                            inv_reg <= inverse_mode_reg;
                            stage_reg <= '0;
                            bf_reg <= '0;
                            state_reg <= S_RDA;
                        end
                        else
                            load_count_reg <= load_count_reg + 1'b1;
                    end
                S_RDA: state_reg <= S_RDB;
                S_RDB:
                begin
                    a_re_reg <= rd_data[ENTRY_W-1:DW];
                    a_im_reg <= rd_data[DW-1:0];
                    state_reg <= S_MUL;
                end
                S_MUL: state_reg <= S_WRA;
                S_WRA: state_reg <= S_WRB;
                S_WRB:
                begin
                    bf_reg <= bf_reg + 1'b1;
                    if (bf_reg == (AW-1)'(POINTS/2 - 1))
                    begin
                        if (stage_reg == 3'(LOG2_POINTS - 1))
                        begin
                            out_cnt_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 1'b1;
                            state_reg <= S_RDA;
                        end
                    end
                    else
                        state_reg <= S_RDA;
                end
                S_OUT:
                begin
                    out_cnt_reg <= out_cnt_reg + 1'b1;
                    if (out_cnt_reg == (AW+1)'(POINTS - 1))
                        state_reg <= S_OUTLAST;
                end
                S_OUTLAST: state_reg <= S_LOAD;
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    always_comb
    begin
        bin_re = rd_data[ENTRY_W-1:DW];
        bin_im = rd_data[DW-1:0];
        if (inv_reg)
        begin
            bin_re = $signed(rd_data[ENTRY_W-1:DW]) >>> LOG2_POINTS;
            bin_im = $signed(rd_data[DW-1:0]) >>> LOG2_POINTS;
        end
    end

    `FFT_ASSERT_IMPL(a_last_ends, clk, rst_n, valid && frame_last |=> !valid,
        "result after frame end")
    `FFT_ASSERT_IMPL(a_valid_busy, clk, rst_n, valid |-> busy,
        "result while idle")
    `FFT_ASSERT_NEVER(a_wr_rd_out, clk, rst_n, ctl.wr_en && (state_reg == S_OUT),
        "write during unload")
    `FFT_ASSERT_IMPL(a_idx_step, clk, rst_n,
        valid && !frame_last |=> valid && bin_index == $past(bin_index) + 1'b1,
        "result index skipped")
endmodule

>>> design/fft_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule

>>> design/fft_bfly.sv
`timescale 1ns / 1ps
// Butterfly datapath: twiddle lookup, complex multiply, add/subtract, saturate.
// Depends on fft_pkg.
module fft_bfly (
    input  logic               clk,
    input  logic [4:0]         tw_k,
    input  logic               inv,
    input  fft_pkg::data_t     a_re,
    input  fft_pkg::data_t     a_im,
    input  fft_pkg::data_t     b_re,
    input  fft_pkg::data_t     b_im,
    input  logic               prod_en,
    output fft_pkg::data_t     sum_re,
    output fft_pkg::data_t     sum_im,
    output fft_pkg::data_t     dif_re,
    output fft_pkg::data_t     dif_im
);
    import fft_pkg::*;

    logic signed [16:0] wr, wi;
    logic signed [39:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [40:0] tr_full, ti_full;
    logic signed [DW+1:0] tr, ti;

    always_comb
    begin
        if (tw_k <= 5'd16)
        begin
            wr = 17'(quarter_cos(tw_k));
            wi = 17'(quarter_cos(5'd16 - tw_k));
        end
        else
        begin
            wr = -17'(quarter_cos(5'd0 - tw_k));
            wi = 17'(quarter_cos(tw_k - 5'd16));
        end
        if (inv)
            wi = -wi;
    end

    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            p_rr_reg <= 40'(wr * b_re);
            p_ii_reg <= 40'(wi * b_im);
            p_ri_reg <= 40'(wr * b_im);
            p_ir_reg <= 40'(wi * b_re);
        end
    end

    assign tr_full = (41'(p_rr_reg) - 41'(p_ii_reg) + 41'sd16384) >>> 15;
    assign ti_full = (41'(p_ri_reg) + 41'(p_ir_reg) + 41'sd16384) >>> 15;
    assign tr = tr_full[DW+1:0];
    assign ti = ti_full[DW+1:0];

    assign sum_re = sat23(25'(a_re) + tr);
    assign sum_im = sat23(25'(a_im) + ti);
    assign dif_re = sat23(25'(a_re) - tr);
    assign dif_im = sat23(25'(a_im) - ti);
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for radix2_fft: feeds whole frames of complex samples and checks every output
// bin against an in-bench fixed-point FFT predictor or a row's typed values. Needs fft_pkg.
module tb;
    import fft_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_FRAMES  = 1;

    typedef enum int { PAT_IMPULSE, PAT_CONST, PAT_ALT, PAT_RAND } pattern_e;

    typedef struct {
        pattern_e          pat;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic              inv;
        logic              typed;
        data_t             exp_re;
        data_t             exp_im;
    } frame_row_t;

    typedef struct {
        data_t      re;
        data_t      im;
        addr_t      idx;
        logic       last;
    } bin_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;
    logic               valid;
    logic signed [22:0] bin_re;
    logic signed [22:0] bin_im;
    logic [5:0]         bin_index;
    logic               frame_last;

    radix2_fft dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_re(sample_re), .sample_im(sample_im),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .valid(valid), .bin_re(bin_re), .bin_im(bin_im),
        .bin_index(bin_index), .frame_last(frame_last)
    );

    // Q1.15 quarter-wave cosine
    int cos_q15 [0:16] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                           20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    longint   buf_re [0:63];
    longint   buf_im [0:63];
    int       load_n;
    logic     mode_inv;
    bin_t     bins_due [$];
    int       errors;
    int       words_in;
    int       bins_out;
    int       frames_done;
    int       idle_cycles;
    logic     typed_on;
    data_t    typed_re;
    data_t    typed_im;

    frame_row_t frame_table [3] = '{
        '{PAT_IMPULSE, 16'sd32767,  -16'sd32768, 1'b0, 1'b1, 23'sd32767,  -23'sd32768},
        '{PAT_IMPULSE, -16'sd32768, 16'sd32767,  1'b1, 1'b1, -23'sd512,   23'sd511},
        '{PAT_ALT,     16'sd32767,  -16'sd32768, 1'b0, 1'b0, 23'sd0,      23'sd0}
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint sat_bin(input longint v);
        if (v > 4194303)
            return 4194303;
        if (v < -4194304)
            return -4194304;
        return v;
    endfunction

    function automatic int rev6(input int i);
        int r;
        r = 0;
        for (int b = 0; b < 6; b++)
            r |= ((i >> b) & 1) << (5 - b);
        return r;
    endfunction

    task automatic run_butterflies(input logic inv);
        int half, k, ia, ib, tk;
        longint wr, wi, tr, ti, ar, ai;
        for (int s = 1; s <= 6; s++)
        begin
            half = 1 << (s - 1);
            for (int p = 0; p < 64; p += 2 * half)
            begin
                for (k = 0; k < half; k++)
                begin
                    ia = p + k;
                    ib = p + k + half;
                    tk = (k << (6 - s)) & 31;
                    if (tk <= 16)
                    begin
                        wr = cos_q15[tk];
                        wi = cos_q15[16 - tk];
                    end
                    else
                    begin
                        wr = -cos_q15[32 - tk];
                        wi = cos_q15[tk - 16];
                    end
                    if (inv)
                        wi = -wi;
                    tr = (wr * buf_re[ib] - wi * buf_im[ib] + 16384) >>> 15;
                    ti = (wr * buf_im[ib] + wi * buf_re[ib] + 16384) >>> 15;
                    ar = buf_re[ia];
                    ai = buf_im[ia];
                    buf_re[ib] = sat_bin(ar - tr);
                    buf_im[ib] = sat_bin(ai - ti);
                    buf_re[ia] = sat_bin(ar + tr);
                    buf_im[ia] = sat_bin(ai + ti);
                end
            end
        end
    endtask

    // Load one word; the 64th word of a frame produces the whole spectrum.
    task automatic predict_word(input logic signed [15:0] re, input logic signed [15:0] im);
        bin_t   b;
        longint r, i;
        buf_re[rev6(load_n)] = re;
        buf_im[rev6(load_n)] = im;
        if (load_n < 63)
        begin
            load_n++;
            return;
        end
        load_n = 0;
        run_butterflies(mode_inv);
        for (int n = 0; n < 64; n++)
        begin
            r = buf_re[n];
            i = buf_im[n];
            if (mode_inv)
            begin
                r = r >>> 6;
                i = i >>> 6;
            end
            b.re   = typed_on ? typed_re : data_t'(r);
            b.im   = typed_on ? typed_im : data_t'(i);
            b.idx  = addr_t'(n);
            b.last = (n == 63);
            bins_due.push_back(b);
        end
    endtask

    task automatic send_word(input logic signed [15:0] re, input logic signed [15:0] im);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        sample_re <= re;
        sample_im <= im;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_in++;
        predict_word(re, im);
    endtask

    task automatic write_mode(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mode_inv = v;
    endtask

    task automatic drain_bins();
        start <= 1'b0;
        while (bins_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(input frame_row_t row);
        logic signed [15:0] re, im;
        int shape;
        write_mode(row.inv);
        typed_on = row.typed;
        typed_re = row.exp_re;
        typed_im = row.exp_im;
        shape = $urandom_range(0, 3);
        for (int n = 0; n < 64; n++)
        begin
            case (row.pat)
                PAT_IMPULSE:
                begin
                    re = (n == 0) ? row.re : 16'sd0;
                    im = (n == 0) ? row.im : 16'sd0;
                end
                PAT_CONST:
                begin
                    re = row.re;
                    im = row.im;
                end
                PAT_ALT:
                begin
                    re = n[0] ? row.im : row.re;
                    im = n[0] ? row.re : row.im;
                end
                default:
                begin
                    re = 16'($urandom);
                    im = 16'($urandom);
                    if (shape == 0)
                    begin
                        re = re >>> 10;
                        im = im >>> 10;
                    end
                end
            endcase
            send_word(re, im);
        end
        drain_bins();
        frames_done++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            bins_out++;
            if (bins_due.size() == 0)
            begin
                $display("%0t: bin %0d with none expected: re %0d im %0d", $time,
                         bin_index, bin_re, bin_im);
                errors++;
            end
            else
            begin
                if (bins_due[0].re !== bin_re || bins_due[0].im !== bin_im ||
                    bins_due[0].idx !== bin_index || bins_due[0].last !== frame_last)
                begin
                    $display("%0t: bin mismatch: expected re %0d im %0d idx %0d last %0b",
                             $time, bins_due[0].re, bins_due[0].im, bins_due[0].idx,
                             bins_due[0].last);
                    $display("%0t:               actual re %0d im %0d idx %0d last %0b",
                             $time, bin_re, bin_im, bin_index, frame_last);
                    errors++;
                end
                void'(bins_due.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        frame_row_t row;
        rst_n       = 1'b0;
        start       = 1'b0;
        sample_re   = '0;
        sample_im   = '0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        errors      = 0;
        words_in    = 0;
        bins_out    = 0;
        frames_done = 0;
        load_n      = 0;
        mode_inv    = 1'b0;
        typed_on    = 1'b0;
        typed_re    = '0;
        typed_im    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (frame_table[r])
            send_frame(frame_table[r]);

        for (int f = 0; f < RANDOM_FRAMES; f++)
        begin
            row = '{PAT_RAND, 16'sd0, 16'sd0, 1'($urandom_range(0, 1)), 1'b0,
                    23'sd0, 23'sd0};
            send_frame(row);
        end

        $display("tb: %0d frames, %0d samples (forward and inverse, impulses, extremes, random)",
                 frames_done, words_in);
        $display("tb: %0d bins checked, %0d mismatches", bins_out, errors);
        if (errors == 0 && bins_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

>>> radix2_fft.f
+incdir+design
design/fft_pkg.sv
design/fft_ram.sv
design/fft_bfly.sv
design/radix2_fft.sv
tb/tb.sv
